>>> hdl/assert_macros.svh
// Assertion macros shared by the calibrator RTL.
// Bodies compile away when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define SGC_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`define SGC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication violated");
`define SGC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");
`else
`define SGC_ASSERT_NEVER(label, clk, rst_n, cond)
`define SGC_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define SGC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> hdl/sgc_pkg.sv
// Shared types, constants and helpers for the stillness gravity calibrator.
// No dependencies; the RTL modules and the testbench refer to it by scoped names.
package sgc_pkg;

    localparam int DATA_W     = 24;
    localparam int LEN_CFG_W  = 7;
    localparam int REQ_CFG_W  = 9;
    localparam int THR_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int WINDOW_DEPTH_DEF = 64;
    localparam int COUNT_MAX_DEF    = 256;

    localparam logic [LEN_CFG_W-1:0]     LEN_RST     = 7'd32;
    localparam logic [REQ_CFG_W-1:0]     REQ_RST     = 9'd128;
    localparam logic [THR_W-1:0]         THR_RST     = 16'd1966;
    localparam logic signed [DATA_W-1:0] GRAVITY_RST = 24'sd642908;

    localparam logic OP_RESTART = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REQUIRED_COUNT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STDDEV_THRESHOLD = 2'd2;

    typedef struct packed {
        logic                     opcode;
        logic signed [DATA_W-1:0] sample;
    } t_in_item;

    typedef struct packed {
        logic                     window_full;
        logic signed [DATA_W-1:0] window_mean;
        logic                     still;
        logic                     calibrated;
        logic                     done_now;
        logic signed [DATA_W-1:0] gravity;
    } t_out_item;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_item;

    typedef struct packed {
        logic load_item;
        logic read_old;
        logic write_sample;
        logic start_stats;
        logic mul_first;
        logic mul_second;
        logic compare;
        logic decide;
        logic gdiv_start;
        logic gravity_take;
        logic restart;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic restart;
        logic calibrated;
        logic window_full;
        logic still;
        logic reached;
        logic scan_busy;
        logic div_busy;
    } t_status;

    function automatic int max_of(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

>>> hdl/sgc_chan_if.sv
// Valid/ready channel interface used for input, result and config beats.
// The payload type is set per instance; depends on nothing else.
interface sgc_chan_if #(parameter type t_payload = logic);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> hdl/sgc_divider.sv
// Restoring divider, one quotient bit per cycle, rounding to nearest with
// ties away from zero. Depends on sgc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sgc_divider #(
    parameter int DVD_W = 34,
    parameter int DVS_W = 9
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic signed [DVD_W-1:0]          i_dividend,
    input  logic [DVS_W-1:0]                 i_divisor,
    output logic                             o_busy,
    output logic signed [sgc_pkg::DATA_W-1:0] o_quotient
);

    localparam int NUM_W  = DVD_W + 1;
    localparam int STEP_W = $clog2(NUM_W + 1);

    logic              r_busy;
    logic [STEP_W-1:0] r_step;
    logic [NUM_W-1:0]  r_num;
    logic [DVS_W-1:0]  r_rem;
    logic [DVS_W-1:0]  r_d;
    logic              r_neg;

    logic signed [DVD_W-1:0] neg_dvd;
    logic [DVD_W-1:0]        mag;
    logic [DVS_W:0]          rem_sh;
    logic [DVS_W:0]          rem_sub;
    logic                    fits;
    logic [NUM_W-1:0]        q_neg;

    assign neg_dvd = -i_dividend;
    assign mag     = i_dividend[DVD_W-1] ? neg_dvd : i_dividend;
    assign rem_sh  = {r_rem, r_num[NUM_W-1]};
    assign fits    = rem_sh >= {1'b0, r_d};
    assign rem_sub = rem_sh - {1'b0, r_d};
    assign q_neg   = NUM_W'(0) - r_num;

    assign o_busy     = r_busy;
    assign o_quotient = r_neg ? $signed(q_neg[sgc_pkg::DATA_W-1:0])
                              : $signed(r_num[sgc_pkg::DATA_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= STEP_W'(NUM_W);
        end else if (r_busy) begin
            r_step <= r_step - STEP_W'(1);
            if (r_step == STEP_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Half the divisor is added up front so truncation rounds to nearest.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= NUM_W'(mag) + NUM_W'(i_divisor >> 1);
            r_rem <= '0;
            r_d   <= i_divisor;
            r_neg <= i_dividend[DVD_W-1];
        end else if (r_busy) begin
            r_num <= {r_num[NUM_W-2:0], fits};
            r_rem <= fits ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
        end
    end

    `SGC_ASSERT_NEVER(a_start_while_busy, i_clk, i_rst_n, i_start && r_busy)

endmodule

>>> hdl/sgc_datapath.sv
// Datapath: window memory, running sums, variance test, still-window
// accumulation and result register. Depends on sgc_pkg, sgc_divider and assert_macros.svh.
`include "assert_macros.svh"

module sgc_datapath #(
    parameter int WINDOW_DEPTH = sgc_pkg::WINDOW_DEPTH_DEF,
    parameter int COUNT_MAX    = sgc_pkg::COUNT_MAX_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sgc_pkg::t_in_item   i_item,
    input  logic                i_cfg_we,
    input  sgc_pkg::t_cfg_item  i_cfg,
    input  sgc_pkg::t_cmd       i_cmd,
    output sgc_pkg::t_status    o_status,
    output sgc_pkg::t_out_item  o_result
);

    localparam int DATA_W = sgc_pkg::DATA_W;
    localparam int ADDR_W = $clog2(WINDOW_DEPTH);
    localparam int LEN_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int CNT_W  = $clog2(COUNT_MAX + 1);
    localparam int SUM_W  = DATA_W + ADDR_W + 1;
    localparam int MAG_W  = SUM_W - 1;
    localparam int SQ1_W  = 2 * DATA_W - 1;
    localparam int SQ_W   = SQ1_W + ADDR_W;
    localparam int NSQ_W  = SQ_W + LEN_W;
    localparam int SSQ_W  = 2 * MAG_W;
    localparam int TN_W   = sgc_pkg::THR_W + LEN_W;
    localparam int TSQ_W  = 2 * TN_W;
    localparam int CMP_W  = sgc_pkg::max_of(sgc_pkg::max_of(NSQ_W, SSQ_W), TSQ_W) + 1;
    localparam int MSUM_W = DATA_W + CNT_W;
    localparam int DVD_W  = sgc_pkg::max_of(SUM_W, MSUM_W);
    localparam int DVS_W  = sgc_pkg::max_of(LEN_W, CNT_W);

    function automatic logic [LEN_W-1:0] clamp_len(input logic [sgc_pkg::LEN_CFG_W-1:0] v);
        logic [LEN_W-1:0] r;
        if (v == '0) begin
            r = LEN_W'(1);
        end else if (32'(v) > WINDOW_DEPTH) begin
            r = LEN_W'(WINDOW_DEPTH);
        end else begin
            r = LEN_W'(v);
        end
        return r;
    endfunction

    function automatic logic [CNT_W-1:0] clamp_cnt(input logic [sgc_pkg::REQ_CFG_W-1:0] v);
        logic [CNT_W-1:0] r;
        if (v == '0) begin
            r = CNT_W'(1);
        end else if (32'(v) > COUNT_MAX) begin
            r = CNT_W'(COUNT_MAX);
        end else begin
            r = CNT_W'(v);
        end
        return r;
    endfunction

    // Configuration
    logic [LEN_W-1:0]          r_len;
    logic [CNT_W-1:0]          r_req;
    logic [sgc_pkg::THR_W-1:0] r_thr;

    // Item and window state
    logic                      r_op;
    logic signed [DATA_W-1:0]  r_x;
    logic signed [DATA_W-1:0]  mem [WINDOW_DEPTH];
    logic signed [DATA_W-1:0]  r_rd_data;
    logic [ADDR_W-1:0]         r_wp;
    logic [LEN_W-1:0]          r_fill;
    logic signed [SUM_W-1:0]   r_sum;

    // Variance scan
    logic                      r_scan_on;
    logic [ADDR_W-1:0]         r_scan_idx;
    logic                      r_scan_rd_vld;
    logic                      r_sq_vld;
    logic [SQ1_W-1:0]          r_sq;
    logic [SQ_W-1:0]           r_sqsum;
    logic [MAG_W-1:0]          r_mag;
    logic [NSQ_W-1:0]          r_nsq;
    logic [SSQ_W-1:0]          r_ssq;
    logic [TN_W-1:0]           r_tn;
    logic [TSQ_W-1:0]          r_tsq;

    // Calibration state and result fields
    logic [CNT_W-1:0]          r_cnt;
    logic signed [MSUM_W-1:0]  r_msum;
    logic                      r_reach;
    logic                      r_cal;
    logic signed [DATA_W-1:0]  r_gravity;
    logic                      r_res_full;
    logic signed [DATA_W-1:0]  r_res_mean;
    logic                      r_still;
    logic                      r_res_done;
    sgc_pkg::t_out_item        r_out;

    logic [ADDR_W-1:0]          wp_eff;
    logic [LEN_W-1:0]           wp_inc;
    logic [ADDR_W-1:0]          wp_next;
    logic [LEN_W-1:0]           fill_next;
    logic signed [DATA_W-1:0]   old_term;
    logic signed [SUM_W-1:0]    sum_next;
    logic signed [SUM_W-1:0]    neg_sum;
    logic [MAG_W-1:0]           mag;
    logic                       rd_en;
    logic [ADDR_W-1:0]          rd_addr;
    logic                       scan_last;
    logic signed [2*DATA_W-1:0] sq_full;
    logic [CNT_W-1:0]           cnt_inc;
    logic                       len_write;
    logic                       div_start;
    logic signed [DVD_W-1:0]    div_dividend;
    logic [DVS_W-1:0]           div_divisor;
    logic                       div_busy;
    logic signed [DATA_W-1:0]   div_q;

    // A write pointer left past a shortened window wraps to the first entry.
    assign wp_eff    = (LEN_W'(r_wp) < r_len) ? r_wp : '0;
    assign wp_inc    = LEN_W'(wp_eff) + LEN_W'(1);
    assign wp_next   = (wp_inc >= r_len) ? '0 : ADDR_W'(wp_inc);
    assign fill_next = (r_fill < r_len) ? r_fill + LEN_W'(1) : r_fill;
    assign old_term  = (r_fill >= r_len) ? r_rd_data : '0;
    assign sum_next  = r_sum - SUM_W'(old_term) + SUM_W'(r_x);
    assign neg_sum   = -r_sum;
    assign mag       = r_sum[SUM_W-1] ? MAG_W'(neg_sum) : MAG_W'(r_sum);
    assign rd_en     = i_cmd.read_old | r_scan_on;
    assign rd_addr   = r_scan_on ? r_scan_idx : wp_eff;
    assign scan_last = (LEN_W'(r_scan_idx) + LEN_W'(1)) == r_len;
    assign sq_full   = r_rd_data * r_rd_data;
    assign cnt_inc   = r_cnt + CNT_W'(1);
    assign len_write = i_cfg_we && (i_cfg.index == sgc_pkg::CFG_WINDOW_LENGTH);

    assign div_start    = i_cmd.start_stats | i_cmd.gdiv_start;
    assign div_dividend = i_cmd.gdiv_start ? DVD_W'(r_msum) : DVD_W'(r_sum);
    assign div_divisor  = i_cmd.gdiv_start ? DVS_W'(r_cnt) : DVS_W'(r_len);

    sgc_divider #(
        .DVD_W (DVD_W),
        .DVS_W (DVS_W)
    ) u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_busy     (div_busy),
        .o_quotient (div_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= clamp_len(sgc_pkg::LEN_RST);
            r_req <= clamp_cnt(sgc_pkg::REQ_RST);
            r_thr <= sgc_pkg::THR_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg.index)
                sgc_pkg::CFG_WINDOW_LENGTH: begin
                    r_len <= clamp_len(i_cfg.data[sgc_pkg::LEN_CFG_W-1:0]);
                end
                sgc_pkg::CFG_REQUIRED_COUNT: begin
                    r_req <= clamp_cnt(i_cfg.data[sgc_pkg::REQ_CFG_W-1:0]);
                end
                sgc_pkg::CFG_STDDEV_THRESHOLD: begin
                    r_thr <= i_cfg.data[sgc_pkg::THR_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || len_write) begin
            r_wp   <= '0;
            r_fill <= '0;
            r_sum  <= '0;
        end else if (i_cmd.write_sample) begin
            r_wp   <= wp_next;
            r_fill <= fill_next;
            r_sum  <= sum_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.write_sample) begin
            mem[wp_eff] <= r_x;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_on     <= 1'b0;
            r_scan_idx    <= '0;
            r_scan_rd_vld <= 1'b0;
            r_sq_vld      <= 1'b0;
        end else begin
            r_scan_rd_vld <= r_scan_on;
            r_sq_vld      <= r_scan_rd_vld;
            if (i_cmd.start_stats) begin
                r_scan_on  <= 1'b1;
                r_scan_idx <= '0;
            end else if (r_scan_on) begin
                if (scan_last) begin
                    r_scan_on <= 1'b0;
                end else begin
                    r_scan_idx <= r_scan_idx + ADDR_W'(1);
                end
            end
        end
    end

    // Exact test: n*sum(x^2) < sum(x)^2 + (threshold*n)^2.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_op <= i_item.opcode;
            r_x  <= i_item.sample;
        end
        r_sq <= sq_full[SQ1_W-1:0];
        if (i_cmd.start_stats) begin
            r_sqsum <= '0;
            r_mag   <= mag;
        end else if (r_sq_vld) begin
            r_sqsum <= r_sqsum + SQ_W'(r_sq);
        end
        if (i_cmd.mul_first) begin
            r_nsq <= NSQ_W'(r_sqsum) * NSQ_W'(r_len);
            r_ssq <= SSQ_W'(r_mag) * SSQ_W'(r_mag);
            r_tn  <= TN_W'(r_thr) * TN_W'(r_len);
        end
        if (i_cmd.mul_second) begin
            r_tsq <= TSQ_W'(r_tn) * TSQ_W'(r_tn);
        end
        if (i_cmd.out_load) begin
            r_out.window_full <= r_res_full;
            r_out.window_mean <= r_res_mean;
            r_out.still       <= r_still;
            r_out.calibrated  <= r_cal;
            r_out.done_now    <= r_res_done;
            r_out.gravity     <= r_gravity;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_full <= 1'b0;
            r_res_mean <= '0;
            r_still    <= 1'b0;
            r_res_done <= 1'b0;
        end else if (i_cmd.load_item) begin
            r_res_full <= 1'b0;
            r_res_mean <= '0;
            r_still    <= 1'b0;
            r_res_done <= 1'b0;
        end else begin
            if (i_cmd.write_sample) begin
                r_res_full <= (fill_next == r_len);
            end
            if (i_cmd.mul_first) begin
                r_res_mean <= div_q;
            end
            if (i_cmd.compare) begin
                r_still <= CMP_W'(r_nsq) < (CMP_W'(r_ssq) + CMP_W'(r_tsq));
            end
            if (i_cmd.gravity_take) begin
                r_res_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_msum    <= '0;
            r_reach   <= 1'b0;
            r_cal     <= 1'b0;
            r_gravity <= sgc_pkg::GRAVITY_RST;
        end else if (i_cmd.restart) begin
            r_cnt  <= '0;
            r_msum <= '0;
            r_cal  <= 1'b0;
        end else if (i_cmd.decide) begin
            if (r_still) begin
                r_cnt   <= cnt_inc;
                r_msum  <= r_msum + MSUM_W'(r_res_mean);
                r_reach <= cnt_inc >= r_req;
            end else begin
                r_cnt   <= '0;
                r_msum  <= '0;
                r_reach <= 1'b0;
            end
        end else if (i_cmd.gravity_take) begin
            r_gravity <= div_q;
            r_cal     <= 1'b1;
            r_cnt     <= '0;
            r_msum    <= '0;
            r_reach   <= 1'b0;
        end
    end

    assign o_status.restart     = (r_op == sgc_pkg::OP_RESTART);
    assign o_status.calibrated  = r_cal;
    assign o_status.window_full = r_res_full;
    assign o_status.still       = r_still;
    assign o_status.reached     = r_reach;
    assign o_status.scan_busy   = r_scan_on | r_scan_rd_vld | r_sq_vld;
    assign o_status.div_busy    = div_busy;
    assign o_result             = r_out;

    `SGC_ASSERT_NEVER(a_fill_bound, i_clk, i_rst_n, r_fill > r_len)
    `SGC_ASSERT_NEVER(a_read_port_clash, i_clk, i_rst_n, i_cmd.read_old && r_scan_on)

endmodule

>>> hdl/sgc_ctrl.sv
// Controller: sequences one item through the datapath and owns the input
// and result handshakes. Depends on sgc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sgc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output sgc_pkg::t_cmd    o_cmd,
    input  sgc_pkg::t_status i_status
);

    typedef enum logic [13:0] {
        S_IDLE     = 14'b00000000000001,
        S_DISPATCH = 14'b00000000000010,
        S_WRITE    = 14'b00000000000100,
        S_FULLCHK  = 14'b00000000001000,
        S_STATS    = 14'b00000000010000,
        S_WAIT     = 14'b00000000100000,
        S_MUL1     = 14'b00000001000000,
        S_MUL2     = 14'b00000010000000,
        S_CMP      = 14'b00000100000000,
        S_DECIDE   = 14'b00001000000000,
        S_REACHCHK = 14'b00010000000000,
        S_GWAIT    = 14'b00100000000000,
        S_GTAKE    = 14'b01000000000000,
        S_FINISH   = 14'b10000000000000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (i_status.restart) begin
                    o_cmd.restart = 1'b1;
                    n_state       = S_FINISH;
                end else if (i_status.calibrated) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.read_old = 1'b1;
                    n_state        = S_WRITE;
                end
            end
            S_WRITE: begin
                o_cmd.write_sample = 1'b1;
                n_state            = S_FULLCHK;
            end
            S_FULLCHK: begin
                n_state = i_status.window_full ? S_STATS : S_FINISH;
            end
            S_STATS: begin
                o_cmd.start_stats = 1'b1;
                n_state           = S_WAIT;
            end
            S_WAIT: begin
                if (!i_status.scan_busy && !i_status.div_busy) begin
                    n_state = S_MUL1;
                end
            end
            S_MUL1: begin
                o_cmd.mul_first = 1'b1;
                n_state         = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul_second = 1'b1;
                n_state          = S_CMP;
            end
            S_CMP: begin
                o_cmd.compare = 1'b1;
                n_state       = S_DECIDE;
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state      = i_status.still ? S_REACHCHK : S_FINISH;
            end
            S_REACHCHK: begin
                if (i_status.reached) begin
                    o_cmd.gdiv_start = 1'b1;
                    n_state          = S_GWAIT;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_GWAIT: begin
                if (!i_status.div_busy) begin
                    n_state = S_GTAKE;
                end
            end
            S_GTAKE: begin
                o_cmd.gravity_take = 1'b1;
                n_state            = S_FINISH;
            end
            S_FINISH: begin
                // The result register may load once its previous beat is gone or is being taken.
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    `SGC_ASSERT_NEXT(a_accept_dispatch, i_clk, i_rst_n, i_in_valid && o_in_ready, r_state == S_DISPATCH)
    `SGC_ASSERT_IMPLY(a_idle_quiet, i_clk, i_rst_n, r_state == S_IDLE, !i_status.scan_busy && !i_status.div_busy)

endmodule

>>> hdl/stillness_gravity_calibrator.sv
// Stillness gravity calibrator: one item at a time, result held in an output register.
// Restart or a sample while calibrated goes straight to the result; a sample that leaves
// the window short of full is written first. A full window adds the serial memory scan,
// the bit-serial mean divider and the variance compare, the reach check when it is still,
// and the gravity divide on the window that completes calibration. The default window
// length is 32. Synchronous active-low reset clears all control state, not the window memory.
module stillness_gravity_calibrator #(
    parameter int WINDOW_DEPTH = sgc_pkg::WINDOW_DEPTH_DEF,
    parameter int COUNT_MAX    = sgc_pkg::COUNT_MAX_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    sgc_chan_if.sink       i_in,
    sgc_chan_if.source     o_out,
    sgc_chan_if.sink       i_cfg
);

    sgc_pkg::t_cmd    cmd;
    sgc_pkg::t_status status;

    assign i_cfg.ready = 1'b1;

    sgc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    sgc_datapath #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .COUNT_MAX    (COUNT_MAX)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_in.payload),
        .i_cfg_we (i_cfg.valid),
        .i_cfg    (i_cfg.payload),
        .i_cmd    (cmd),
        .o_status (status),
        .o_result (o_out.payload)
    );

endmodule

>>> verif/tb_stillness_gravity_calibrator.sv
// Self-checking testbench for the stillness gravity calibrator: directed corner cases,
// then random calibration sequences, each result checked against a built-in predictor.
// Depends on sgc_pkg, sgc_chan_if and the stillness_gravity_calibrator RTL.
module tb_stillness_gravity_calibrator;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          DATA_W       = sgc_pkg::DATA_W;
    localparam int          CFG_DATA_W   = sgc_pkg::CFG_DATA_W;
    localparam logic        OP_SAMPLE    = 1'b0;
    localparam int unsigned RANDOM_ITEMS = 1300;
    localparam int unsigned MAX_SHOWN    = 10;

    logic i_clk = 1'b0;
    logic i_rst_n;

    sgc_chan_if #(.t_payload(sgc_pkg::t_in_item))  in_ch ();
    sgc_chan_if #(.t_payload(sgc_pkg::t_out_item)) out_ch ();
    sgc_chan_if #(.t_payload(sgc_pkg::t_cfg_item)) cfg_ch ();

    stillness_gravity_calibrator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    always #1 i_clk = ~i_clk;

    // Predictor state, mirroring what the block keeps.
    logic signed [DATA_W-1:0] win_mem [sgc_pkg::WINDOW_DEPTH_DEF];
    int unsigned              win_wp, win_fill, win_len, req_cnt, thr_lvl, still_run;
    longint                   win_acc, mean_acc;
    bit                       calib_flag;
    logic signed [DATA_W-1:0] grav_est;

    sgc_pkg::t_out_item calib_report_q [$];
    int unsigned bad_reports  = 0;
    int unsigned live_items   = 0;
    int unsigned report_hold  = 0;
    bit          src_gaps     = 1'b1;
    bit          sink_stalls  = 1'b1;
    bit          in_offering  = 1'b0;

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Nearest integer quotient, ties away from zero; d is positive.
    function automatic longint round_div(input longint v, input longint d);
        longint mag, q;
        mag = (v < 0) ? -v : v;
        q = (mag + d / 2) / d;
        return (v < 0) ? -q : q;
    endfunction

    // Population variance below threshold squared, kept exact in integers:
    // n*sum(x^2) - sum(x)^2 < (thr*n)^2.
    function automatic bit window_quiet(input int unsigned n);
        longint      sq, lhs, rhs, t;
        int unsigned i;
        sq = 0;
        for (i = 0; i < n; i++) sq += longint'(win_mem[i]) * longint'(win_mem[i]);
        lhs = sq * longint'(n);
        t = longint'(thr_lvl) * longint'(n);
        rhs = win_acc * win_acc + t * t;
        return lhs < rhs;
    endfunction

    function automatic void calib_reset();
        win_wp = 0;
        win_fill = 0;
        win_acc = 0;
        still_run = 0;
        mean_acc = 0;
        calib_flag = 1'b0;
        grav_est = sgc_pkg::GRAVITY_RST;
        win_len = 32'(sgc_pkg::LEN_RST);
        req_cnt = 32'(sgc_pkg::REQ_RST);
        thr_lvl = 32'(sgc_pkg::THR_RST);
    endfunction

    function automatic void apply_setting(input logic [sgc_pkg::CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
        unique case (idx)
            sgc_pkg::CFG_WINDOW_LENGTH: begin
                win_len = 32'(data[sgc_pkg::LEN_CFG_W-1:0]);
                if (win_len == 0) win_len = 1;
                else if (win_len > sgc_pkg::WINDOW_DEPTH_DEF) win_len = sgc_pkg::WINDOW_DEPTH_DEF;
                // A new length empties the window.
                win_wp = 0;
                win_fill = 0;
                win_acc = 0;
            end
            sgc_pkg::CFG_REQUIRED_COUNT: begin
                req_cnt = 32'(data[sgc_pkg::REQ_CFG_W-1:0]);
                if (req_cnt == 0) req_cnt = 1;
                else if (req_cnt > sgc_pkg::COUNT_MAX_DEF) req_cnt = sgc_pkg::COUNT_MAX_DEF;
            end
            sgc_pkg::CFG_STDDEV_THRESHOLD: thr_lvl = 32'(data[sgc_pkg::THR_W-1:0]);
            default: ;
        endcase
    endfunction

    function automatic void calib_step(input sgc_pkg::t_in_item beat,
                                       output sgc_pkg::t_out_item rep);
        int unsigned wp;
        longint      mean, avg;
        rep = '0;
        if (beat.opcode == sgc_pkg::OP_RESTART) begin
            calib_flag = 1'b0;
            still_run = 0;
            mean_acc = 0;
        end else if (!calib_flag) begin
            wp = (win_wp < win_len) ? win_wp : 0;
            if (win_fill >= win_len) win_acc -= longint'(win_mem[wp]);
            win_mem[wp] = beat.sample;
            win_acc += longint'(beat.sample);
            wp++;
            win_wp = (wp >= win_len) ? 0 : wp;
            if (win_fill < win_len) win_fill++;
            if (win_fill >= win_len) begin
                rep.window_full = 1'b1;
                mean = round_div(win_acc, longint'(win_len));
                rep.window_mean = mean[DATA_W-1:0];
                if (window_quiet(win_len)) begin
                    rep.still = 1'b1;
                    still_run++;
                    mean_acc += mean;
                    if (still_run >= req_cnt) begin
                        avg = round_div(mean_acc, longint'(still_run));
                        grav_est = avg[DATA_W-1:0];
                        calib_flag = 1'b1;
                        rep.done_now = 1'b1;
                        still_run = 0;
                        mean_acc = 0;
                    end
                end else begin
                    still_run = 0;
                    mean_acc = 0;
                end
            end
        end
        rep.calibrated = calib_flag;
        rep.gravity = grav_est;
    endfunction

    task automatic send_item(input logic op, input logic signed [DATA_W-1:0] value);
        sgc_pkg::t_in_item  beat;
        sgc_pkg::t_out_item rep;
        int unsigned        gap;
        beat.opcode = op;
        beat.sample = value;
        gap = src_gaps ? pick_gap() : 0;
        if (gap > 0 && in_offering) begin
            in_ch.valid <= 1'b0;
            in_offering = 1'b0;
        end
        repeat (gap) @(posedge i_clk);
        in_ch.valid <= 1'b1;
        in_ch.payload <= beat;
        in_offering = 1'b1;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        if (op == sgc_pkg::OP_RESTART || !calib_flag) live_items++;
        calib_step(beat, rep);
        calib_report_q.push_back(rep);
    endtask

    // Stop offering and wait until every predicted result has come back.
    task automatic settle();
        if (in_offering) begin
            in_ch.valid <= 1'b0;
            in_offering = 1'b0;
        end
        while (calib_report_q.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [sgc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.payload <= '{index: idx, data: data};
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        apply_setting(idx, data);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic test_reset_state();
        send_item(sgc_pkg::OP_RESTART, 24'h000000);
        send_item(OP_SAMPLE, 24'h7FFFFF);
        send_item(OP_SAMPLE, 24'h800000);
        send_item(OP_SAMPLE, 24'h000000);
        send_item(OP_SAMPLE, 24'hFFFFFF);
    endtask

    // Length 0 acts as 1, so every sample is a full window of zero variance.
    task automatic test_single_entry_window();
        settle();
        write_reg(sgc_pkg::CFG_WINDOW_LENGTH, 16'd0);
        write_reg(sgc_pkg::CFG_REQUIRED_COUNT, 16'd1);
        write_reg(sgc_pkg::CFG_STDDEV_THRESHOLD, 16'hFFFF);
        send_item(OP_SAMPLE, 24'h7FFFFF);
        send_item(OP_SAMPLE, 24'h00007B);
        send_item(sgc_pkg::OP_RESTART, 24'h5A5A5A);
        send_item(OP_SAMPLE, 24'h800000);
        send_item(sgc_pkg::OP_RESTART, 24'h000000);
        settle();
        write_reg(sgc_pkg::CFG_STDDEV_THRESHOLD, 16'd0);
        send_item(OP_SAMPLE, 24'h000007);
    endtask

    // Full-scale pairs: a mean tie rounding away from zero and a wide window that breaks the run.
    task automatic test_pair_window();
        settle();
        write_reg(sgc_pkg::CFG_WINDOW_LENGTH, 16'd2);
        write_reg(sgc_pkg::CFG_REQUIRED_COUNT, 16'd2);
        write_reg(sgc_pkg::CFG_STDDEV_THRESHOLD, 16'hFFFF);
        send_item(OP_SAMPLE, 24'h7FFFFF);
        send_item(OP_SAMPLE, 24'h800000);
        send_item(OP_SAMPLE, 24'h800000);
        send_item(OP_SAMPLE, 24'h800000);
        send_item(OP_SAMPLE, 24'h800001);
        send_item(sgc_pkg::OP_RESTART, 24'hA5A5A5);
    endtask

    // Lowering the required count mid-run completes on the next still window and divides by the actual count.
    task automatic test_count_lowered();
        settle();
        write_reg(sgc_pkg::CFG_WINDOW_LENGTH, 16'd1);
        write_reg(sgc_pkg::CFG_REQUIRED_COUNT, 16'd5);
        write_reg(sgc_pkg::CFG_STDDEV_THRESHOLD, 16'd1000);
        send_item(OP_SAMPLE, 24'd100);
        send_item(OP_SAMPLE, 24'd101);
        send_item(OP_SAMPLE, 24'd102);
        settle();
        write_reg(sgc_pkg::CFG_REQUIRED_COUNT, 16'd2);
        send_item(OP_SAMPLE, 24'd104);
    endtask

    // The receiver holds off while the sender keeps offering, so the input stalls.
    task automatic test_backpressure();
        int unsigned k;
        settle();
        write_reg(sgc_pkg::CFG_WINDOW_LENGTH, 16'd4);
        write_reg(sgc_pkg::CFG_REQUIRED_COUNT, 16'd3);
        write_reg(sgc_pkg::CFG_STDDEV_THRESHOLD, 16'd5000);
        src_gaps = 1'b0;
        report_hold = 300;
        for (k = 0; k < 16; k++) send_item(OP_SAMPLE, DATA_W'(-20000 + $urandom_range(0, 6000)));
        settle();
        src_gaps = 1'b1;
    endtask

    task automatic pick_settings();
        logic [CFG_DATA_W-1:0] len_v, req_v, thr_v;
        int unsigned           r;
        r = $urandom_range(0, 99);
        if (r < 55) len_v = CFG_DATA_W'($urandom_range(1, 8));
        else if (r < 82) len_v = CFG_DATA_W'($urandom_range(9, 32));
        else if (r < 88) len_v = CFG_DATA_W'(sgc_pkg::WINDOW_DEPTH_DEF);
        else if (r < 92) len_v = 16'd0;
        else if (r < 95) len_v = 16'h007F;
        else len_v = CFG_DATA_W'($urandom());
        r = $urandom_range(0, 99);
        if (r < 60) req_v = CFG_DATA_W'($urandom_range(1, 4));
        else if (r < 80) req_v = CFG_DATA_W'($urandom_range(5, 12));
        else if (r < 85) req_v = 16'd0;
        else if (r < 88) req_v = CFG_DATA_W'(sgc_pkg::COUNT_MAX_DEF);
        else if (r < 91) req_v = 16'h01FF;
        else req_v = CFG_DATA_W'($urandom());
        r = $urandom_range(0, 99);
        if (r < 50) thr_v = CFG_DATA_W'($urandom_range(200, 3000));
        else if (r < 70) thr_v = CFG_DATA_W'($urandom_range(3000, 65535));
        else if (r < 78) thr_v = 16'd0;
        else if (r < 86) thr_v = 16'hFFFF;
        else thr_v = CFG_DATA_W'($urandom_range(1, 199));
        // Sometimes the window is kept across phases.
        if ($urandom_range(0, 2) != 0) write_reg(sgc_pkg::CFG_WINDOW_LENGTH, len_v);
        write_reg(sgc_pkg::CFG_REQUIRED_COUNT, req_v);
        write_reg(sgc_pkg::CFG_STDDEV_THRESHOLD, thr_v);
    endtask

    // Phases of near-constant samples with noise scaled to the threshold, so that
    // calibration completes often; mixed with motion, restarts and ignored samples.
    task automatic test_random_calibration();
        int unsigned target, burst, k, r, amp;
        int          base, v;
        target = live_items + RANDOM_ITEMS;
        while (live_items < target) begin
            settle();
            pick_settings();
            src_gaps = ($urandom_range(0, 3) != 0);
            sink_stalls = ($urandom_range(0, 3) != 0);
            base = int'($urandom_range(0, 32'hFFFFFF)) - 8388608;
            r = $urandom_range(0, 9);
            if (thr_lvl == 0) amp = $urandom_range(0, 3);
            else if (r < 7) amp = $urandom_range(0, thr_lvl);
            else if (r < 9) amp = $urandom_range(thr_lvl, 4 * thr_lvl + 1);
            else amp = $urandom_range(0, 1000000);
            burst = $urandom_range(10, 60);
            for (k = 0; k < burst; k++) begin
                r = $urandom_range(0, 99);
                if (calib_flag && r < 75) begin
                    send_item(sgc_pkg::OP_RESTART, DATA_W'($urandom()));
                end else if (!calib_flag && r < 3) begin
                    send_item(sgc_pkg::OP_RESTART, DATA_W'($urandom()));
                end else if (r < 8) begin
                    send_item(OP_SAMPLE, DATA_W'($urandom()));
                end else begin
                    if ($urandom_range(0, 19) == 0) base += int'($urandom_range(0, 200)) - 100;
                    v = base + int'($urandom_range(0, 2 * amp)) - int'(amp);
                    if (v > 8388607) v = 8388607;
                    if (v < -8388608) v = -8388608;
                    send_item(OP_SAMPLE, DATA_W'(v));
                end
                if ($urandom_range(0, 49) == 0) settle();
            end
        end
    endtask

    initial begin : result_sink
        int unsigned n;
        out_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            n = 0;
            if (report_hold > 0) begin
                n = report_hold;
                report_hold = 0;
            end else if (sink_stalls) begin
                n = pick_gap();
            end
            if (n > 0) begin
                out_ch.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        sgc_pkg::t_out_item want, got;
        string              wrong;
        if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            got = out_ch.payload;
            if (calib_report_q.size() == 0) begin
                bad_reports++;
                if (bad_reports <= MAX_SHOWN) begin
                    $display("unexpected result beat: full=%0d mean=%0d still=%0d",
                             got.window_full, got.window_mean, got.still);
                    $display("  cal=%0d done=%0d grav=%0d",
                             got.calibrated, got.done_now, got.gravity);
                end
            end else begin
                want = calib_report_q.pop_front();
                wrong = "";
                if (got.window_full !== want.window_full) wrong = {wrong, " window_full"};
                if (got.window_mean !== want.window_mean) wrong = {wrong, " window_mean"};
                if (got.still !== want.still) wrong = {wrong, " still"};
                if (got.calibrated !== want.calibrated) wrong = {wrong, " calibrated"};
                if (got.done_now !== want.done_now) wrong = {wrong, " done_now"};
                if (got.gravity !== want.gravity) wrong = {wrong, " gravity"};
                if (wrong != "") begin
                    bad_reports++;
                    if (bad_reports <= MAX_SHOWN) begin
                        $display("result mismatch in%s at %0t", wrong, $realtime);
                        $display("  expected full=%0d mean=%0d still=%0d cal=%0d done=%0d grav=%0d",
                                 want.window_full, want.window_mean, want.still,
                                 want.calibrated, want.done_now, want.gravity);
                        $display("  actual   full=%0d mean=%0d still=%0d cal=%0d done=%0d grav=%0d",
                                 got.window_full, got.window_mean, got.still,
                                 got.calibrated, got.done_now, got.gravity);
                    end
                end
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.payload = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.payload = '0;
        calib_reset();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_single_entry_window();
        test_pair_window();
        test_count_lowered();
        test_backpressure();
        test_random_calibration();

        settle();
        repeat (150) @(posedge i_clk);
        if (bad_reports == 0) begin
            $display("tb_stillness_gravity_calibrator passed");
        end else begin
            $display("tb_stillness_gravity_calibrator failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("tb_stillness_gravity_calibrator failed");
        $finish;
    end

endmodule
